// File: design/cgsd_pkg.sv
// Shared types, codes and helper functions of the compact geometry stream decoder.
`timescale 1ns / 1ps

package cgsd_pkg;

	// Record kinds as given on the first byte of a request.
	localparam logic [1:0] KIND_POINTS   = 2'd0;
	localparam logic [1:0] KIND_SEGMENTS = 2'd1;
	localparam logic [1:0] KIND_RECTS    = 2'd2;
	localparam logic [1:0] KIND_ARCS     = 2'd3;

	// Code forms of one field.
	localparam logic [1:0] FORM_SIGNED = 2'd0;
	localparam logic [1:0] FORM_SIZE   = 2'd1;
	localparam logic [1:0] FORM_ANGLE  = 2'd2;

	localparam logic [3:0] NIB_SHORT_PREFIX = 4'h8;
	localparam logic [3:0] NIB_SIZE_PREFIX  = 4'hF;
	localparam logic [15:0] ANGLE_STEP      = 16'd5760;
	localparam logic [15:0] ANGLE_OFFSET    = 16'd23040;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] req_type;
		logic       start_of_request;
	} cgsd_in_t;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  field_pos;
		logic        record_done;
	} cgsd_out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        pending;
		logic [7:0]  prefix;
		logic [2:0]  idx;
		logic [15:0] run_x;
		logic [15:0] run_y;
	} cgsd_state_t;

	function automatic logic [3:0] record_len(input logic [1:0] kind);
		logic [3:0] len;
		case (kind)
			KIND_POINTS: len = 4'd2;
			KIND_ARCS:   len = 4'd6;
			default:     len = 4'd4;
		endcase
		return len;
	endfunction

	function automatic logic [1:0] field_form(input logic [1:0] kind, input logic [2:0] idx);
		logic [1:0] form;
		form = FORM_SIGNED;
		if ((kind == KIND_RECTS || kind == KIND_ARCS) && (idx == 3'd2 || idx == 3'd3))
			form = FORM_SIZE;
		if (kind == KIND_ARCS && (idx == 3'd4 || idx == 3'd5))
			form = FORM_ANGLE;
		return form;
	endfunction

endpackage

// File: design/cgsd_if.sv
// Valid/ready stream interfaces for the byte input and the decoded field output.
`timescale 1ns / 1ps

interface cgsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] req_type;
	logic       start_of_request;

	modport source(output valid, output data_byte, output req_type, output start_of_request,
		input ready);
	modport sink(input valid, input data_byte, input req_type, input start_of_request,
		output ready);
endinterface

interface cgsd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [2:0]  field_pos;
	logic        record_done;

	modport source(output valid, output value, output field_pos, output record_done,
		input ready);
	modport sink(input valid, input value, input field_pos, input record_done,
		output ready);
endinterface

// File: design/cgsd_field_decode.sv
// Combinational decode of one byte against the decoder state: result and next state.
`timescale 1ns / 1ps

module cgsd_field_decode (
	input  cgsd_pkg::cgsd_state_t state,
	input  cgsd_pkg::cgsd_in_t    item,
	output logic                  emit,
	output cgsd_pkg::cgsd_out_t   result,
	output cgsd_pkg::cgsd_state_t next_state
);

	cgsd_pkg::cgsd_state_t cur;
	logic [1:0]  form;
	logic [3:0]  len;
	logic [3:0]  idx_inc;
	logic [7:0]  b;
	logic        two;
	logic [15:0] raw;
	logic [15:0] angle_short;

	assign b = item.data_byte;

	always_comb begin
		// A new request clears everything, including an unfinished two-byte code.
		cur = state;
		if (item.start_of_request) begin
			cur.kind    = item.req_type;
			cur.pending = 1'b0;
			cur.prefix  = 8'd0;
			cur.idx     = 3'd0;
			cur.run_x   = 16'd0;
			cur.run_y   = 16'd0;
		end
	end

	assign form        = cgsd_pkg::field_form(cur.kind, cur.idx);
	assign len         = cgsd_pkg::record_len(cur.kind);
	assign idx_inc     = {1'b0, cur.idx} + 4'd1;
	assign angle_short = 16'({12'd0, b[3:0]} * cgsd_pkg::ANGLE_STEP) - cgsd_pkg::ANGLE_OFFSET;

	always_comb begin
		two = 1'b0;
		raw = 16'd0;
		if (cur.pending) begin
			if (form == cgsd_pkg::FORM_ANGLE)
				raw = {cur.prefix, b};
			else
				raw = {(form == cgsd_pkg::FORM_SIGNED && cur.prefix[3]) ? 4'hF : 4'h0,
					cur.prefix[3:0], b};
		end else begin
			case (form)
				cgsd_pkg::FORM_SIZE: begin
					two = (b[7:4] == cgsd_pkg::NIB_SIZE_PREFIX);
					raw = {8'd0, b};
				end
				cgsd_pkg::FORM_ANGLE: begin
					two = (b[7:4] != cgsd_pkg::NIB_SHORT_PREFIX);
					raw = angle_short;
				end
				default: begin
					two = (b[7:4] == cgsd_pkg::NIB_SHORT_PREFIX);
					raw = {{8{b[7]}}, b};
				end
			endcase
		end
	end

	assign emit = !two;

	always_comb begin
		next_state = cur;
		result.value       = raw;
		result.field_pos   = cur.idx;
		result.record_done = (idx_inc >= len);
		if (two) begin
			next_state.pending = 1'b1;
			next_state.prefix  = b;
		end else begin
			next_state.pending = 1'b0;
			next_state.idx     = (idx_inc >= len) ? 3'd0 : idx_inc[2:0];
			// Every kind but points carries its first pair as deltas on running totals.
			if (cur.kind != cgsd_pkg::KIND_POINTS) begin
				if (cur.idx == 3'd0) begin
					next_state.run_x = cur.run_x + raw;
					result.value     = cur.run_x + raw;
				end else if (cur.idx == 3'd1) begin
					next_state.run_y = cur.run_y + raw;
					result.value     = cur.run_y + raw;
				end else if (cur.kind == cgsd_pkg::KIND_SEGMENTS && cur.idx == 3'd2) begin
					result.value = cur.run_x + raw;
				end else if (cur.kind == cgsd_pkg::KIND_SEGMENTS && cur.idx == 3'd3) begin
					result.value = cur.run_y + raw;
				end
			end
		end
	end

endmodule

// File: design/compact_geometry_stream_decoder.sv
// Top level of the compact geometry stream decoder.
`timescale 1ns / 1ps

// Decodes a compact coordinate list one byte per transaction into 16-bit fields of
// points, segments, rectangles or arcs. A byte is taken in every cycle whenever the
// single output register is empty or is being emptied in the same cycle, so the
// sustained rate is one byte per cycle; the result of a byte is offered in the cycle after
// its transaction. A byte that opens a two-byte code produces no output transaction.
// The decoder state and the output register are the only storage in the path.

module compact_geometry_stream_decoder (
	input logic       clk,
	input logic       arst_n,
	cgsd_in_if.sink   bytes,
	cgsd_out_if.source fields
);

	cgsd_pkg::cgsd_state_t state_q;
	cgsd_pkg::cgsd_state_t next_state;
	cgsd_pkg::cgsd_in_t    item;
	cgsd_pkg::cgsd_out_t   result;
	cgsd_pkg::cgsd_out_t   result_q;
	logic                  emit;
	logic                  out_valid_q;
	logic                  accept;

	assign item.data_byte        = bytes.data_byte;
	assign item.req_type         = bytes.req_type;
	assign item.start_of_request = bytes.start_of_request;

	assign bytes.ready = !out_valid_q || fields.ready;
	assign accept      = bytes.valid && bytes.ready;

	cgsd_field_decode u_decode (
		.state      (state_q),
		.item       (item),
		.emit       (emit),
		.result     (result),
		.next_state (next_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				state_q <= next_state;
			if (accept)
				out_valid_q <= emit;
			else if (fields.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit)
			result_q <= result;
	end

	assign fields.valid       = out_valid_q;
	assign fields.value       = result_q.value;
	assign fields.field_pos   = result_q.field_pos;
	assign fields.record_done = result_q.record_done;

endmodule

// File: design/cgsd_checker.sv
// Port-level assertions for the compact geometry stream decoder, bound to the top level.
`timescale 1ns / 1ps

module cgsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic [1:0]  req_type,
	input logic        start_of_request,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  field_pos,
	input logic        record_done
);

	// An empty output register never holds back the input.
	assert property (@(posedge clk) disable iff (!arst_n) !out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// A single-byte x code opening a points request yields position 0 next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && start_of_request && req_type == cgsd_pkg::KIND_POINTS &&
			data_byte[7:4] != cgsd_pkg::NIB_SHORT_PREFIX)
		|=> (out_valid && field_pos == 3'd0 && !record_done))
		else $error("first field of a points request not delivered");

	// Records have two, four or six fields, so they end only at odd positions.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_done)
		|-> (field_pos == 3'd1 || field_pos == 3'd3 || field_pos == 3'd5))
		else $error("record completed at an impossible position");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (field_pos <= 3'd5))
		else $error("field position beyond any record");

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output transaction withdrawn before acceptance");

endmodule

bind compact_geometry_stream_decoder cgsd_checker u_cgsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (bytes.valid),
	.in_ready         (bytes.ready),
	.data_byte        (bytes.data_byte),
	.req_type         (bytes.req_type),
	.start_of_request (bytes.start_of_request),
	.out_valid        (fields.valid),
	.out_ready        (fields.ready),
	.field_pos        (fields.field_pos),
	.record_done      (fields.record_done)
);

// File: tb/cgsd_field_checker.sv
// Field checker: predicts every decoded field from the accepted bytes and compares the output.
`timescale 1ns / 1ps

module cgsd_field_checker (
	input  logic clk,
	input  logic arst_n,
	cgsd_in_if   bytes,
	cgsd_out_if  fields,
	output int   fail_count,
	output int   fields_waiting,
	output int   fields_checked,
	output int   records_checked
);

	// Decoder state as the predictor sees it.
	logic [1:0]  kind_q;
	logic        prefix_open;
	logic [7:0]  prefix_q;
	logic [2:0]  pos_q;
	logic [15:0] total_x;
	logic [15:0] total_y;

	cgsd_pkg::cgsd_out_t expected_fields[$];

	function automatic logic [1:0] form_of(input logic [1:0] kind, input logic [2:0] pos);
		logic [1:0] f;
		f = cgsd_pkg::FORM_SIGNED;
		case (kind)
			cgsd_pkg::KIND_RECTS: begin
				if (pos == 3'd2 || pos == 3'd3)
					f = cgsd_pkg::FORM_SIZE;
			end
			cgsd_pkg::KIND_ARCS: begin
				if (pos == 3'd4 || pos == 3'd5)
					f = cgsd_pkg::FORM_ANGLE;
				else if (pos == 3'd2 || pos == 3'd3)
					f = cgsd_pkg::FORM_SIZE;
			end
			default: f = cgsd_pkg::FORM_SIGNED;
		endcase
		return f;
	endfunction

	function automatic logic [2:0] last_pos_of(input logic [1:0] kind);
		logic [2:0] p;
		case (kind)
			cgsd_pkg::KIND_POINTS: p = 3'd1;
			cgsd_pkg::KIND_ARCS:   p = 3'd5;
			default:               p = 3'd3;
		endcase
		return p;
	endfunction

	// Advances the predicted state by one byte and queues the field it completes, if any.
	task automatic predict_field(input logic [7:0] b, input logic [1:0] kind_in, input logic sor);
		logic [1:0]          f;
		logic [15:0]         v;
		logic                two_byte;
		cgsd_pkg::cgsd_out_t r;
		if (sor) begin
			kind_q      = kind_in;
			prefix_open = 1'b0;
			prefix_q    = 8'h00;
			pos_q       = 3'd0;
			total_x     = 16'h0000;
			total_y     = 16'h0000;
		end
		f = form_of(kind_q, pos_q);
		if (prefix_open) begin
			if (f == cgsd_pkg::FORM_ANGLE) begin
				v = {prefix_q, b};
			end else begin
				v = {4'h0, prefix_q[3:0], b};
				if (f == cgsd_pkg::FORM_SIGNED && prefix_q[3])
					v[15:12] = 4'hF;
			end
			prefix_open = 1'b0;
		end else begin
			case (f)
				cgsd_pkg::FORM_SIGNED: two_byte = (b[7:4] == cgsd_pkg::NIB_SHORT_PREFIX);
				cgsd_pkg::FORM_SIZE:   two_byte = (b[7:4] == cgsd_pkg::NIB_SIZE_PREFIX);
				default:               two_byte = (b[7:4] != cgsd_pkg::NIB_SHORT_PREFIX);
			endcase
			if (two_byte) begin
				prefix_open = 1'b1;
				prefix_q    = b;
				return;
			end
			case (f)
				cgsd_pkg::FORM_SIGNED: v = {{8{b[7]}}, b};
				cgsd_pkg::FORM_SIZE:   v = {8'h00, b};
				default: v = 16'((int'(b[3:0]) - 4) * int'(cgsd_pkg::ANGLE_STEP));
			endcase
		end
		// The first pair of each non-point record moves the running totals; the far end
		// of a segment is relative to them but leaves them alone.
		if (kind_q != cgsd_pkg::KIND_POINTS) begin
			if (pos_q == 3'd0) begin
				total_x = total_x + v;
				v       = total_x;
			end else if (pos_q == 3'd1) begin
				total_y = total_y + v;
				v       = total_y;
			end else if (kind_q == cgsd_pkg::KIND_SEGMENTS) begin
				v = (pos_q == 3'd2) ? total_x + v : total_y + v;
			end
		end
		r.value       = v;
		r.field_pos   = pos_q;
		r.record_done = (pos_q >= last_pos_of(kind_q));
		pos_q         = r.record_done ? 3'd0 : pos_q + 3'd1;
		expected_fields.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cgsd_pkg::cgsd_out_t want;
		if (!arst_n) begin
			kind_q      = cgsd_pkg::KIND_POINTS;
			prefix_open = 1'b0;
			prefix_q    = 8'h00;
			pos_q       = 3'd0;
			total_x     = 16'h0000;
			total_y     = 16'h0000;
			expected_fields.delete();
			fail_count      = 0;
			fields_waiting  = 0;
			fields_checked  = 0;
			records_checked = 0;
		end else begin
			// The output side is handled first: a field leaves no earlier than the cycle after its byte.
			if (fields.valid && fields.ready) begin
				if (expected_fields.size() == 0) begin
					$error("unexpected field: value %h, field_pos %0d, record_done %0b",
						fields.value, fields.field_pos, fields.record_done);
					fail_count++;
				end else begin
					want = expected_fields.pop_front();
					fields_checked++;
					if (want.record_done)
						records_checked++;
					if (fields.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, fields.value);
						fail_count++;
					end
					if (fields.field_pos !== want.field_pos) begin
						$error("field_pos: expected %0d, got %0d", want.field_pos,
							fields.field_pos);
						fail_count++;
					end
					if (fields.record_done !== want.record_done) begin
						$error("record_done: expected %0b, got %0b", want.record_done,
							fields.record_done);
						fail_count++;
					end
				end
			end
			if (bytes.valid && bytes.ready)
				predict_field(bytes.data_byte, bytes.req_type, bytes.start_of_request);
			fields_waiting = expected_fields.size();
		end
	end

	final begin
		if (expected_fields.size() != 0)
			$error("%0d expected fields never arrived", expected_fields.size());
	end
endmodule

// File: tb/tb_top.sv
// Testbench top: clock, reset, byte stimulus with idling phases, and the verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 4;
	localparam int PHASE_BYTES = 232;

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int requests_sent;
	int fail_count;
	int fields_waiting;
	int fields_checked;
	int records_checked;

	// Idling per phase: none, sender only, receiver only, both lightly.
	int phase_idle[PHASES]  = '{0, 50, 0, 8};
	int phase_stall[PHASES] = '{0, 0, 50, 8};

	cgsd_in_if  bytes();
	cgsd_out_if fields();

	compact_geometry_stream_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.fields (fields)
	);

	cgsd_field_checker field_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes           (bytes),
		.fields          (fields),
		.fail_count      (fail_count),
		.fields_waiting  (fields_waiting),
		.fields_checked  (fields_checked),
		.records_checked (records_checked)
	);

	always #10 clk = ~clk;

	// Receiver: stalls at random according to the current phase.
	initial begin
		fields.ready <= 1'b0;
		forever begin
			@(posedge clk);
			fields.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: gives up when no transaction happens on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((bytes.valid && bytes.ready) || (fields.valid && fields.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL compact_geometry_stream_decoder");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic [1:0] kind, input logic sor);
		while ($urandom_range(99) < send_idle_pct) begin
			bytes.valid <= 1'b0;
			@(posedge clk);
		end
		bytes.valid            <= 1'b1;
		bytes.data_byte        <= b;
		bytes.req_type         <= kind;
		bytes.start_of_request <= sor;
		@(posedge clk);
		while (!bytes.ready)
			@(posedge clk);
		bytes_sent++;
		if (sor)
			requests_sent++;
	endtask

	// Bytes biased towards the prefixes of two-byte codes and the edges of each form.
	function automatic logic [7:0] pick_code_byte();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1: b = {cgsd_pkg::NIB_SHORT_PREFIX, 4'($urandom_range(15))};
			2, 3: b = {cgsd_pkg::NIB_SIZE_PREFIX, 4'($urandom_range(15))};
			4: begin
				case ($urandom_range(5))
					0:       b = 8'h00;
					1:       b = 8'h7F;
					2:       b = 8'h80;
					3:       b = 8'hEF;
					4:       b = 8'h8F;
					default: b = 8'hFF;
				endcase
			end
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	task automatic send_directed();
		// Points: largest single positive byte, then a negative two-byte code.
		send_byte(8'h7F, cgsd_pkg::KIND_POINTS, 1'b1);
		send_byte(8'h88, cgsd_pkg::KIND_ARCS, 1'b0);
		send_byte(8'h00, cgsd_pkg::KIND_ARCS, 1'b0);
		// Segments: far end taken relative to the totals, including a negative delta.
		send_byte(8'h10, cgsd_pkg::KIND_SEGMENTS, 1'b1);
		send_byte(8'h20, cgsd_pkg::KIND_RECTS, 1'b0);
		send_byte(8'h05, cgsd_pkg::KIND_POINTS, 1'b0);
		send_byte(8'hFB, cgsd_pkg::KIND_ARCS, 1'b0);
		// Rectangles: largest one-byte size and largest two-byte size.
		send_byte(8'h00, cgsd_pkg::KIND_RECTS, 1'b1);
		send_byte(8'h00, cgsd_pkg::KIND_POINTS, 1'b0);
		send_byte(8'hEF, cgsd_pkg::KIND_SEGMENTS, 1'b0);
		send_byte(8'hFF, cgsd_pkg::KIND_ARCS, 1'b0);
		send_byte(8'hFF, cgsd_pkg::KIND_POINTS, 1'b0);
		// Arcs: two-byte x, zero sizes, a nibble angle and a raw angle.
		send_byte(8'h87, cgsd_pkg::KIND_ARCS, 1'b1);
		send_byte(8'hFF, cgsd_pkg::KIND_POINTS, 1'b0);
		send_byte(8'hFF, cgsd_pkg::KIND_RECTS, 1'b0);
		send_byte(8'h00, cgsd_pkg::KIND_SEGMENTS, 1'b0);
		send_byte(8'hF0, cgsd_pkg::KIND_ARCS, 1'b0);
		send_byte(8'h00, cgsd_pkg::KIND_POINTS, 1'b0);
		send_byte(8'h80, cgsd_pkg::KIND_RECTS, 1'b0);
		send_byte(8'h12, cgsd_pkg::KIND_SEGMENTS, 1'b0);
		send_byte(8'h34, cgsd_pkg::KIND_ARCS, 1'b0);
		// A prefix left open when the next request begins is dropped.
		send_byte(8'h01, cgsd_pkg::KIND_POINTS, 1'b1);
		send_byte(8'h8A, cgsd_pkg::KIND_POINTS, 1'b0);
		send_byte(8'h01, cgsd_pkg::KIND_RECTS, 1'b1);
	endtask

	// Requests of random kind and length; a few long ones let the totals wrap.
	task automatic send_requests(input int n_bytes);
		int         left;
		int         len;
		logic [1:0] kind;
		left = n_bytes;
		while (left > 0) begin
			len  = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			len  = (len > left) ? left : len;
			kind = 2'($urandom_range(3));
			for (int i = 0; i < len; i++)
				send_byte(pick_code_byte(), (i == 0) ? kind : 2'($urandom_range(3)), i == 0);
			left -= len;
		end
	endtask

	initial begin
		bytes.valid            <= 1'b0;
		bytes.data_byte        <= 8'h00;
		bytes.req_type         <= cgsd_pkg::KIND_POINTS;
		bytes.start_of_request <= 1'b0;
		arst_n                 <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_sent     = 0;
		requests_sent  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct  = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			send_requests(PHASE_BYTES);
		end
		bytes.valid <= 1'b0;
		// Let the checker take in the last accepted byte before looking at its queue.
		repeat (2) @(posedge clk);
		while (fields_waiting != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d requests under %0d idling phases.", bytes_sent,
			requests_sent, PHASES);
		$display("Compared %0d decoded fields, %0d of which closed a record.", fields_checked,
			records_checked);
		if (fail_count == 0 && fields_waiting == 0)
			$display("PASS compact_geometry_stream_decoder");
		else
			$display("FAIL compact_geometry_stream_decoder");
		$finish;
	end
endmodule
